// ----- sv/mera_pkg.sv -----
// shared types and event codes for the mouse event report aggregator
`timescale 1ns / 1ps
package mera_pkg;

  localparam int unsigned TYPE_W  = 5;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BTN_W   = 3;

  localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
  localparam logic [TYPE_W-1:0] TYPE_REL  = 5'd2;

  localparam logic [CODE_W-1:0] AXIS_X         = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_Y         = 10'd1;
  localparam logic [CODE_W-1:0] AXIS_WHEEL     = 10'd8;
  localparam logic [CODE_W-1:0] KEY_BTN_LEFT   = 10'd272;
  localparam logic [CODE_W-1:0] KEY_BTN_RIGHT  = 10'd273;
  localparam logic [CODE_W-1:0] KEY_BTN_MIDDLE = 10'd274;
  localparam logic [CODE_W-1:0] SYNC_REPORT    = 10'd0;

  localparam logic [VALUE_W-1:0] KEY_STATE_DOWN   = 32'd1;
  localparam logic [VALUE_W-1:0] KEY_STATE_REPEAT = 32'd2;

  // selector values for axes and buttons
  localparam logic [1:0] SEL_X      = 2'd0;
  localparam logic [1:0] SEL_Y      = 2'd1;
  localparam logic [1:0] SEL_WHEEL  = 2'd2;
  localparam logic [1:0] SEL_LEFT   = 2'd0;
  localparam logic [1:0] SEL_RIGHT  = 2'd1;
  localparam logic [1:0] SEL_MIDDLE = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic RECORD_MOUSE = 1'b0;
  localparam logic RECORD_KEY   = 1'b1;

  typedef enum logic [1:0] {
    OP_REL,
    OP_BTN,
    OP_KEY,
    OP_SYNC
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic [1:0]                sel;
    logic                      flag;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
  } op_t;

endpackage

// ----- sv/mera_front.sv -----
// front end: classifies each event request into a back-end operation
`timescale 1ns / 1ps
module mera_front (
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic [mera_pkg::TYPE_W-1:0]             in_event_type,
  input  logic [mera_pkg::CODE_W-1:0]             in_event_code,
  input  logic signed [mera_pkg::VALUE_W-1:0]     in_event_value,
  output logic                                    push,
  output mera_pkg::op_t                           push_op
);

  logic useful;

  always_comb begin
    useful          = 1'b0;
    push_op.kind    = mera_pkg::OP_SYNC;
    push_op.sel     = mera_pkg::SEL_X;
    push_op.flag    = 1'b0;
    push_op.code    = in_event_code;
    push_op.value   = in_event_value;
    case (in_event_type)
      mera_pkg::TYPE_REL: begin
        push_op.kind = mera_pkg::OP_REL;
        case (in_event_code)
          mera_pkg::AXIS_X: begin
            useful      = 1'b1;
            push_op.sel = mera_pkg::SEL_X;
          end
          mera_pkg::AXIS_Y: begin
            useful      = 1'b1;
            push_op.sel = mera_pkg::SEL_Y;
          end
          mera_pkg::AXIS_WHEEL: begin
            useful      = 1'b1;
            push_op.sel = mera_pkg::SEL_WHEEL;
          end
          default: useful = 1'b0;
        endcase
      end
      mera_pkg::TYPE_KEY: begin
        push_op.flag = (in_event_value != '0);
        case (in_event_code)
          mera_pkg::KEY_BTN_LEFT: begin
            useful       = 1'b1;
            push_op.kind = mera_pkg::OP_BTN;
            push_op.sel  = mera_pkg::SEL_LEFT;
          end
          mera_pkg::KEY_BTN_RIGHT: begin
            useful       = 1'b1;
            push_op.kind = mera_pkg::OP_BTN;
            push_op.sel  = mera_pkg::SEL_RIGHT;
          end
          mera_pkg::KEY_BTN_MIDDLE: begin
            useful       = 1'b1;
            push_op.kind = mera_pkg::OP_BTN;
            push_op.sel  = mera_pkg::SEL_MIDDLE;
          end
          default: begin
            push_op.kind = mera_pkg::OP_KEY;
            useful = (in_event_value == '0) ||
                     (in_event_value == mera_pkg::KEY_STATE_DOWN) ||
                     (in_event_value == mera_pkg::KEY_STATE_REPEAT);
          end
        endcase
      end
      mera_pkg::TYPE_SYNC: begin
        push_op.kind = mera_pkg::OP_SYNC;
        useful       = (in_event_code == mera_pkg::SYNC_REPORT);
      end
      default: useful = 1'b0;
    endcase
  end

  // ignored events are accepted but never queued
  assign push = in_valid && !in_stall && useful;

endmodule

// ----- sv/mera_queue.sv -----
// short operation queue between front and back end
`timescale 1ns / 1ps
module mera_queue #(
  parameter int unsigned DEPTH = mera_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mera_pkg::op_t push_op,
  input  logic          pop,
  output logic          q_valid,
  output mera_pkg::op_t q_op,
  output logic          full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mera_pkg::op_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_valid = (count_r != '0);
  assign full    = (count_r == FULL_CNT);
  assign q_op    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> (count_r != FULL_CNT))
    else $error("queue pushed while full");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ----- sv/mera_back.sv -----
// back end: accumulators, button state and the result register
`timescale 1ns / 1ps
module mera_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  mera_pkg::op_t                       q_op,
  output logic                                pop,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_record_kind,
  output logic signed [mera_pkg::VALUE_W-1:0] out_move_x,
  output logic signed [mera_pkg::VALUE_W-1:0] out_move_y,
  output logic [mera_pkg::BTN_W-1:0]          out_button_bits,
  output logic signed [mera_pkg::VALUE_W-1:0] out_wheel_steps,
  output logic [mera_pkg::CODE_W-1:0]         out_key_code,
  output logic                                out_key_down
);

  localparam int unsigned W = mera_pkg::VALUE_W;

  logic signed [W-1:0] sum_x_r, sum_x_nxt;
  logic signed [W-1:0] sum_y_r, sum_y_nxt;
  logic signed [W-1:0] sum_wheel_r, sum_wheel_nxt;
  logic [mera_pkg::BTN_W-1:0] cur_btn_r, cur_btn_nxt;
  logic [mera_pkg::BTN_W-1:0] rep_btn_r, rep_btn_nxt;
  logic pending_r, pending_nxt;
  logic out_valid_r, out_valid_nxt;
  logic load_out;

  logic                       kind_r, kind_nxt;
  logic signed [W-1:0]        mx_r, mx_nxt, my_r, my_nxt, mw_r, mw_nxt;
  logic [mera_pkg::BTN_W-1:0] bb_r, bb_nxt;
  logic [mera_pkg::CODE_W-1:0] kc_r, kc_nxt;
  logic                       kd_r, kd_nxt;

  logic signed [W-1:0] acc_in, acc_sat;
  logic signed [W:0]   acc_sum;
  logic [mera_pkg::BTN_W-1:0] btn_mask;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  // one shared saturating adder
  always_comb begin
    case (q_op.sel)
      mera_pkg::SEL_Y:     acc_in = sum_y_r;
      mera_pkg::SEL_WHEEL: acc_in = sum_wheel_r;
      default:             acc_in = sum_x_r;
    endcase
    acc_sum = {acc_in[W-1], acc_in} + {q_op.value[W-1], q_op.value};
    if (acc_sum[W] != acc_sum[W-1]) begin
      acc_sat = acc_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[W-1:0];
    end
    btn_mask = mera_pkg::BTN_W'(1) << q_op.sel;
  end

  always_comb begin
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_wheel_nxt = sum_wheel_r;
    cur_btn_nxt   = cur_btn_r;
    rep_btn_nxt   = rep_btn_r;
    pending_nxt   = pending_r;
    load_out      = 1'b0;
    kind_nxt      = kind_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mw_nxt        = mw_r;
    bb_nxt        = bb_r;
    kc_nxt        = kc_r;
    kd_nxt        = kd_r;
    if (pop) begin
      case (q_op.kind)
        mera_pkg::OP_REL: begin
          pending_nxt = 1'b1;
          case (q_op.sel)
            mera_pkg::SEL_Y:     sum_y_nxt = acc_sat;
            mera_pkg::SEL_WHEEL: sum_wheel_nxt = acc_sat;
            default:             sum_x_nxt = acc_sat;
          endcase
        end
        mera_pkg::OP_BTN: begin
          pending_nxt = 1'b1;
          cur_btn_nxt = q_op.flag ? (cur_btn_r | btn_mask) : (cur_btn_r & ~btn_mask);
        end
        mera_pkg::OP_KEY: begin
          load_out = 1'b1;
          kind_nxt = mera_pkg::RECORD_KEY;
          mx_nxt   = '0;
          my_nxt   = '0;
          mw_nxt   = '0;
          bb_nxt   = '0;
          kc_nxt   = q_op.code;
          kd_nxt   = q_op.flag;
        end
        mera_pkg::OP_SYNC: begin
          if (pending_r && (sum_x_r != '0 || sum_y_r != '0 || sum_wheel_r != '0 ||
                            cur_btn_r != rep_btn_r)) begin
            load_out = 1'b1;
            kind_nxt = mera_pkg::RECORD_MOUSE;
            mx_nxt   = sum_x_r;
            my_nxt   = sum_y_r;
            mw_nxt   = sum_wheel_r;
            bb_nxt   = cur_btn_r;
            kc_nxt   = '0;
            kd_nxt   = 1'b0;
          end
          rep_btn_nxt   = cur_btn_r;
          sum_x_nxt     = '0;
          sum_y_nxt     = '0;
          sum_wheel_nxt = '0;
          pending_nxt   = 1'b0;
        end
        default: pending_nxt = pending_r;
      endcase
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_wheel_r <= '0;
      cur_btn_r   <= '0;
      rep_btn_r   <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_wheel_r <= sum_wheel_nxt;
      cur_btn_r   <= cur_btn_nxt;
      rep_btn_r   <= rep_btn_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    mw_r   <= mw_nxt;
    bb_r   <= bb_nxt;
    kc_r   <= kc_nxt;
    kd_r   <= kd_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = kind_r;
  assign out_move_x      = mx_r;
  assign out_move_y      = my_r;
  assign out_button_bits = bb_r;
  assign out_wheel_steps = mw_r;
  assign out_key_code    = kc_r;
  assign out_key_down    = kd_r;

  a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (q_op.kind == mera_pkg::OP_SYNC) |=>
      (sum_x_r == '0) && (sum_y_r == '0) && (sum_wheel_r == '0) && !pending_r)
    else $error("sync did not clear accumulators");

  a_key_record_clean: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (q_op.kind == mera_pkg::OP_KEY) |=>
      out_valid_r && (kind_r == mera_pkg::RECORD_KEY) && (mx_r == '0) && (bb_r == '0))
    else $error("key record not loaded cleanly");

endmodule

// ----- sv/mouse_event_report_aggregator.sv -----
// top level of the mouse event report aggregator
`timescale 1ns / 1ps
// Takes one input event per cycle when the operation queue has room and returns a
// mouse report on a sync, or a key record for a keyboard key, from an output register.
// An event is decoded combinationally into a QUEUE_DEPTH-entry queue; the back end
// retires one queued operation per cycle, unless a held result is stalled, into the
// accumulators and the output register, so a result passes through a queue entry and
// then the output register. Stall on the result side fills the queue and then raises
// in_stall; motion, button and ignored events never produce a result.
module mouse_event_report_aggregator #(
  parameter int unsigned QUEUE_DEPTH = mera_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mera_pkg::TYPE_W-1:0]         in_event_type,
  input  logic [mera_pkg::CODE_W-1:0]         in_event_code,
  input  logic signed [mera_pkg::VALUE_W-1:0] in_event_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_record_kind,
  output logic signed [mera_pkg::VALUE_W-1:0] out_move_x,
  output logic signed [mera_pkg::VALUE_W-1:0] out_move_y,
  output logic [mera_pkg::BTN_W-1:0]          out_button_bits,
  output logic signed [mera_pkg::VALUE_W-1:0] out_wheel_steps,
  output logic [mera_pkg::CODE_W-1:0]         out_key_code,
  output logic                                out_key_down
);

  logic          push, pop, q_valid, full;
  mera_pkg::op_t push_op, q_op;

  assign in_stall = full;

  mera_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .push           (push),
    .push_op        (push_op)
  );

  mera_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op),
    .full    (full)
  );

  mera_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_record_kind (out_record_kind),
    .out_move_x      (out_move_x),
    .out_move_y      (out_move_y),
    .out_button_bits (out_button_bits),
    .out_wheel_steps (out_wheel_steps),
    .out_key_code    (out_key_code),
    .out_key_down    (out_key_down)
  );

endmodule
